// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file chol_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/chol_pkg.sv -----
`default_nettype none

package chol_pkg;

    typedef logic signed [63:0] q_t;

    typedef enum logic [1:0] {
        FUNC_MAT   = 2'd0,
        FUNC_RHS   = 2'd1,
        FUNC_SOLVE = 2'd2
    } func_t;

    localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t QMIN = 64'sh8000_0000_0000_0000;

    function automatic logic [63:0] mag(input q_t a);
        mag = a[63] ? (64'd0 - 64'(a)) : 64'(a);
    endfunction

    function automatic q_t from_mag(input logic neg, input logic [63:0] m);
        if (neg) begin
            from_mag = m[63] ? QMIN : q_t'(64'd0 - m);
        end else begin
            from_mag = m[63] ? QMAX : q_t'(m);
        end
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic [63:0] s;
        s = 64'(a) + 64'(b);
        if (a[63] == b[63] && s[63] != a[63]) begin
            qadd = a[63] ? QMIN : QMAX;
        end else begin
            qadd = q_t'(s);
        end
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic [63:0] s;
        s = 64'(a) - 64'(b);
        if (a[63] != b[63] && s[63] != a[63]) begin
            qsub = a[63] ? QMIN : QMAX;
        end else begin
            qsub = q_t'(s);
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/chol_mul.sv -----
`default_nettype none

module chol_mul (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire chol_pkg::q_t a,
    input  wire chol_pkg::q_t b,
    output logic              done,
    output chol_pkg::q_t      p
);

    logic [63:0]  x_reg, y_reg;
    logic         neg_reg;
    logic [127:0] prod_reg;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    chol_pkg::q_t p_reg;

    logic [31:0]  xh, yh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb begin
        xh    = step_reg[1] ? x_reg[63:32] : x_reg[31:0];
        yh    = step_reg[0] ? y_reg[63:32] : y_reg[31:0];
        pp    = 64'(xh) * 64'(yh);
        pp_sh = {64'd0, pp} << (32 * (int'(step_reg[0]) + int'(step_reg[1])));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= chol_pkg::mag(a);
                y_reg    <= chol_pkg::mag(b);
                neg_reg  <= a[63] ^ b[63];
                prod_reg <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (step_reg == 3'd4) begin
                    if (prod_reg[127:96] != 32'd0) begin
                        p_reg <= neg_reg ? chol_pkg::QMIN : chol_pkg::QMAX;
                    end else begin
                        p_reg <= chol_pkg::from_mag(neg_reg, prod_reg[95:32]);
                    end
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    prod_reg <= prod_reg + pp_sh;
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

`default_nettype wire

// ----- rtl/chol_div.sv -----
`default_nettype none

module chol_div (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire chol_pkg::q_t a,
    input  wire chol_pkg::q_t b,
    output logic              done,
    output chol_pkg::q_t      q
);

    logic [63:0]  r_reg, lo_reg, y_reg, q_reg;
    logic [5:0]   cnt_reg;
    logic         neg_reg, busy_reg, done_reg;
    chol_pkg::q_t res_reg;

    logic [64:0] rr;
    logic        ge;
    logic [63:0] x_mag, y_mag;

    always_comb begin
        x_mag = chol_pkg::mag(a);
        y_mag = chol_pkg::mag(b);
        rr    = {r_reg, lo_reg[63]};
        ge    = rr >= {1'b0, y_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg <= a[63] ^ b[63];
                if (64'(x_mag[63:32]) >= y_mag) begin
                    res_reg  <= (a[63] ^ b[63]) ? chol_pkg::QMIN : chol_pkg::QMAX;
                    done_reg <= 1'b1;
                end else begin
                    r_reg    <= 64'(x_mag[63:32]);
                    lo_reg   <= {x_mag[31:0], 32'd0};
                    y_reg    <= y_mag;
                    q_reg    <= '0;
                    cnt_reg  <= 6'd63;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                r_reg  <= ge ? 64'(rr - {1'b0, y_reg}) : rr[63:0];
                lo_reg <= {lo_reg[62:0], 1'b0};
                q_reg  <= {q_reg[62:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    res_reg  <= chol_pkg::from_mag(neg_reg, {q_reg[62:0], ge});
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = res_reg;

endmodule

`default_nettype wire

// ----- rtl/chol_sqrt.sv -----
`default_nettype none

module chol_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] v,
    output logic             done,
    output chol_pkg::q_t     r
);

    logic [127:0] src_reg;
    logic [63:0]  rem_reg, root_reg;
    logic [5:0]   cnt_reg;
    logic         busy_reg, done_reg;
    chol_pkg::q_t res_reg;

    logic [63:0] rem_s, trial;
    logic        ge;

    always_comb begin
        rem_s = {rem_reg[61:0], src_reg[127:126]};
        trial = {root_reg[61:0], 2'b01};
        ge    = rem_s >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                src_reg  <= {32'd0, v, 32'd0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'd63;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? rem_s - trial : rem_s;
                root_reg <= {root_reg[62:0], ge};
                src_reg  <= {src_reg[125:0], 2'b00};
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    res_reg  <= chol_pkg::q_t'({root_reg[62:0], ge});
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign r    = res_reg;

endmodule

`default_nettype wire

// ----- rtl/cholesky_linear_solver.sv -----
// channel | direction | handshake           | payload
// s_      | in        | s_valid / s_ready   | s_func s_row s_col s_value
// m_      | out       | m_valid / m_ready   | m_index m_solution m_last m_pivot_error
// cfg_    | in        | cfg_valid/cfg_ready | cfg_data (order)
//
// Load requests are accepted while idle. A solve request keeps the block busy for
// roughly n^3/6 + n^2 multiply-accumulates (memory reads, a four-step multiplier
// and its result stage), plus about n^2/2 divisions and n roots in the
// bit-serial divider and root units. Results are then given one at a time, each
// read from the vector memory first and held while m_ready is low.
// Reset is synchronous and active low; no clearing pass on the memories.
`default_nettype none

module cholesky_linear_solver #(
    parameter int MAX_ORDER = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_func,
    input  wire logic [3:0]   s_row,
    input  wire logic [3:0]   s_col,
    input  wire logic signed [63:0] s_value,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [4:0]   cfg_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [3:0]        m_index,
    output logic signed [63:0] m_solution,
    output logic              m_last,
    output logic              m_pivot_error
);

    localparam int NMAX  = (MAX_ORDER < 16) ? MAX_ORDER : 16;
    localparam int AW    = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int CW    = $clog2(NMAX + 1);
    localparam int DEPTH = NMAX * NMAX;
    localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {PH_FACT, PH_FWD, PH_BACK} phase_t;
    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOP, ST_RD1, ST_RD2, ST_MUL, ST_MWAIT,
        ST_FRD, ST_FGET, ST_UNIT, ST_UWAIT, ST_WRITE, ST_ORD, ST_OGET, ST_OUT
    } state_t;

    function automatic logic [DAW-1:0] caddr(input logic [AW-1:0] r, input logic [AW-1:0] c);
        caddr = DAW'(int'(r) * NMAX + int'(c));
    endfunction

    chol_pkg::q_t coef_mem [DEPTH];
    chol_pkg::q_t vec_mem  [NMAX];
    chol_pkg::q_t coef_q, vec_q;

    state_t         state_reg;
    phase_t         ph_reg;
    logic [CW-1:0]  i_reg, j_reg, k_reg, n_reg;
    logic [4:0]     order_reg;
    logic           err_reg;
    chol_pkg::q_t   acc_reg, a_reg, b_reg, diff_reg, den_reg, piv_reg, res_reg;
    logic           m_valid_reg, m_last_reg, m_perr_reg;
    logic [3:0]     m_index_reg;
    chol_pkg::q_t   m_sol_reg;

    logic [DAW-1:0] coef_raddr, coef_waddr;
    logic [AW-1:0]  vec_raddr, vec_waddr;
    logic           coef_we, vec_we;
    chol_pkg::q_t   coef_wdata, vec_wdata;
    logic           s_acc, k_done, zero_den;
    logic [4:0]     n_clamp;
    logic [CW-1:0]  i_inc, j_inc;

    logic           mul_start, div_start, sqrt_start;
    logic           mul_done, div_done, sqrt_done;
    chol_pkg::q_t   mul_p, div_q, sqrt_r;

    chol_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(a_reg), .b(b_reg), .done(mul_done), .p(mul_p)
    );

    chol_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .a(diff_reg), .b(den_reg), .done(div_done), .q(div_q)
    );

    chol_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .v(chol_pkg::mag(diff_reg)), .done(sqrt_done), .r(sqrt_r)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;
    assign i_inc     = i_reg + CW'(1);
    assign j_inc     = j_reg + CW'(1);
    assign k_done    = (ph_reg == PH_BACK) ? (k_reg == n_reg) : (k_reg == i_reg);
    assign zero_den  = (den_reg == '0);
    assign mul_start = (state_reg == ST_MUL);

    always_comb begin
        if (order_reg == 5'd0) begin
            n_clamp = 5'd1;
        end else if (int'(order_reg) > NMAX) begin
            n_clamp = 5'(NMAX);
        end else begin
            n_clamp = order_reg;
        end
    end

    always_comb begin
        coef_raddr = '0;
        vec_raddr  = '0;
        unique case (state_reg)
            ST_LOOP: begin
                if (ph_reg == PH_FACT) begin
                    coef_raddr = caddr(j_reg[AW-1:0], k_reg[AW-1:0]);
                end else if (ph_reg == PH_FWD) begin
                    coef_raddr = caddr(i_reg[AW-1:0], k_reg[AW-1:0]);
                end else begin
                    coef_raddr = caddr(k_reg[AW-1:0], i_reg[AW-1:0]);
                end
                vec_raddr = k_reg[AW-1:0];
            end
            ST_RD1: coef_raddr = caddr(i_reg[AW-1:0], k_reg[AW-1:0]);
            ST_FRD: begin
                if (ph_reg == PH_FACT) begin
                    coef_raddr = caddr(j_reg[AW-1:0], i_reg[AW-1:0]);
                end else begin
                    coef_raddr = caddr(i_reg[AW-1:0], i_reg[AW-1:0]);
                end
                vec_raddr = i_reg[AW-1:0];
            end
            ST_ORD: vec_raddr = i_reg[AW-1:0];
            ST_IDLE, ST_RD2, ST_MUL, ST_MWAIT, ST_FGET, ST_UNIT, ST_UWAIT,
            ST_WRITE, ST_OGET, ST_OUT: ;
        endcase
    end

    always_comb begin
        coef_we    = 1'b0;
        vec_we     = 1'b0;
        coef_waddr = caddr(s_row[AW-1:0], s_col[AW-1:0]);
        vec_waddr  = s_row[AW-1:0];
        coef_wdata = s_value;
        vec_wdata  = s_value;
        if (s_acc) begin
            coef_we = (s_func == chol_pkg::FUNC_MAT) && (int'(s_row) < NMAX)
                      && (int'(s_col) < NMAX);
            vec_we  = (s_func == chol_pkg::FUNC_RHS) && (int'(s_row) < NMAX);
        end else if (state_reg == ST_WRITE) begin
            coef_waddr = caddr(j_reg[AW-1:0], i_reg[AW-1:0]);
            vec_waddr  = i_reg[AW-1:0];
            coef_wdata = res_reg;
            vec_wdata  = res_reg;
            coef_we    = (ph_reg == PH_FACT);
            vec_we     = (ph_reg != PH_FACT);
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_q <= coef_mem[coef_raddr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we) begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        vec_q <= vec_mem[vec_raddr];
    end

    always_comb begin
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        if (state_reg == ST_UNIT) begin
            if (ph_reg == PH_FACT && j_reg == i_reg) begin
                sqrt_start = 1'b1;
            end else begin
                div_start = !zero_den;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ph_reg      <= PH_FACT;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            n_reg       <= CW'(NMAX);
            order_reg   <= 5'd16;
            err_reg     <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                order_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_func == chol_pkg::FUNC_SOLVE) begin
                        n_reg     <= CW'(n_clamp);
                        ph_reg    <= PH_FACT;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        err_reg   <= 1'b0;
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP: state_reg <= k_done ? ST_FRD : ST_RD1;
                ST_RD1: begin
                    a_reg <= coef_q;
                    if (ph_reg == PH_FACT) begin
                        state_reg <= ST_RD2;
                    end else begin
                        b_reg     <= vec_q;
                        state_reg <= ST_MUL;
                    end
                end
                ST_RD2: begin
                    b_reg     <= coef_q;
                    state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_MWAIT;
                ST_MWAIT: begin
                    if (mul_done) begin
                        acc_reg   <= chol_pkg::qadd(acc_reg, mul_p);
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= ST_LOOP;
                    end
                end
                ST_FRD: state_reg <= ST_FGET;
                ST_FGET: begin
                    if (ph_reg == PH_FACT) begin
                        diff_reg <= chol_pkg::qsub(coef_q, acc_reg);
                        den_reg  <= piv_reg;
                    end else begin
                        diff_reg <= chol_pkg::qsub(vec_q, acc_reg);
                        den_reg  <= coef_q;
                    end
                    state_reg <= ST_UNIT;
                end
                ST_UNIT: begin
                    if (!(ph_reg == PH_FACT && j_reg == i_reg) && zero_den) begin
                        res_reg   <= '0;
                        state_reg <= ST_WRITE;
                    end else begin
                        state_reg <= ST_UWAIT;
                    end
                end
                ST_UWAIT: begin
                    if (sqrt_done || div_done) begin
                        res_reg   <= sqrt_done ? sqrt_r : div_q;
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    acc_reg   <= '0;
                    state_reg <= ST_LOOP;
                    if (ph_reg == PH_FACT) begin
                        if (j_reg == i_reg) begin
                            piv_reg <= res_reg;
                            if (res_reg == '0) begin
                                err_reg <= 1'b1;
                            end
                        end
                        k_reg <= '0;
                        if (j_inc == n_reg) begin
                            if (i_inc == n_reg) begin
                                ph_reg <= PH_FWD;
                                i_reg  <= '0;
                            end else begin
                                i_reg <= i_inc;
                                j_reg <= i_inc;
                            end
                        end else begin
                            j_reg <= j_inc;
                        end
                    end else if (ph_reg == PH_FWD) begin
                        if (i_inc == n_reg) begin
                            ph_reg <= PH_BACK;
                            i_reg  <= n_reg - CW'(1);
                            k_reg  <= n_reg;
                        end else begin
                            i_reg <= i_inc;
                            k_reg <= '0;
                        end
                    end else begin
                        if (i_reg == '0) begin
                            state_reg <= ST_ORD;
                        end else begin
                            k_reg <= i_reg;
                            i_reg <= i_reg - CW'(1);
                        end
                    end
                end
                ST_ORD: state_reg <= ST_OGET;
                ST_OGET: begin
                    m_valid_reg <= 1'b1;
                    m_sol_reg   <= vec_q;
                    m_index_reg <= 4'(i_reg);
                    m_last_reg  <= (i_inc == n_reg);
                    m_perr_reg  <= err_reg;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg     <= i_inc;
                            state_reg <= ST_ORD;
                        end
                    end
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_index       = m_index_reg;
    assign m_solution    = m_sol_reg;
    assign m_last        = m_last_reg;
    assign m_pivot_error = m_perr_reg;

endmodule

`default_nettype wire

// ----- rtl/chol_chk.sv -----
`default_nettype none
`include "assert_macros.svh"

module chol_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_func,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_index,
    input wire logic [63:0] m_solution,
    input wire logic        m_last
);

    `CHK_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_solution) && $stable(m_index), "stalled result changed")
    `CHK_IMPL(a_busy_out, aclk, aresetn, m_valid, !s_ready, "request taken while results pending")
    `CHK_NEXT(a_solve_busy, aclk, aresetn, s_valid && s_ready && s_func == chol_pkg::FUNC_SOLVE, !s_ready, "solve did not hold off requests")
    `CHK_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last, !m_valid && s_ready, "block not idle after last result")

endmodule

bind cholesky_linear_solver chol_chk u_chol_chk (.*);

`default_nettype wire

// ----- verif/cholesky_linear_solver_test.sv -----
`default_nettype none

module cholesky_linear_solver_test;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [3:0]   index;
        chol_pkg::q_t solution;
        logic         last;
        logic         pivot_error;
    } solution_t;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    logic [1:0]   s_func;
    logic [3:0]   s_row;
    logic [3:0]   s_col;
    chol_pkg::q_t s_value;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [4:0]   cfg_data;
    logic         m_valid;
    logic         m_ready;
    logic [3:0]   m_index;
    chol_pkg::q_t m_solution;
    logic         m_last;
    logic         m_pivot_error;

    chol_pkg::q_t coef_model [0:255];
    chol_pkg::q_t rhs_model [0:15];
    logic [4:0]   order_model;
    solution_t    solution_q [$];
    int           errors;
    int           requests;
    int           solves;
    int           results;

    cholesky_linear_solver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_row(s_row),
        .s_col(s_col), .s_value(s_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_index(m_index),
        .m_solution(m_solution), .m_last(m_last), .m_pivot_error(m_pivot_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("cholesky_linear_solver: mismatch");
        $finish;
    end

    // Q32.32 arithmetic with saturation
    function automatic logic [63:0] abs_q(input chol_pkg::q_t a);
        abs_q = a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic chol_pkg::q_t signed_sat(input logic neg, input logic [63:0] m);
        if (neg) begin
            signed_sat = m[63] ? chol_pkg::QMIN : chol_pkg::q_t'(64'd0 - m);
        end else begin
            signed_sat = m[63] ? chol_pkg::QMAX : chol_pkg::q_t'(m);
        end
    endfunction

    function automatic chol_pkg::q_t sat_sum(input chol_pkg::q_t a, input chol_pkg::q_t b,
                                             input logic minus);
        logic [64:0] s;
        s = minus ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            sat_sum = s[64] ? chol_pkg::QMIN : chol_pkg::QMAX;
        end else begin
            sat_sum = chol_pkg::q_t'(s[63:0]);
        end
    endfunction

    function automatic chol_pkg::q_t fx_mul(input chol_pkg::q_t a, input chol_pkg::q_t b);
        logic [127:0] p;
        p = ({64'd0, abs_q(a)} * {64'd0, abs_q(b)}) >> 32;
        if (|p[127:64]) begin
            fx_mul = (a[63] != b[63]) ? chol_pkg::QMIN : chol_pkg::QMAX;
        end else begin
            fx_mul = signed_sat(a[63] != b[63], p[63:0]);
        end
    endfunction

    function automatic chol_pkg::q_t fx_div(input chol_pkg::q_t a, input chol_pkg::q_t b);
        logic [63:0]  x;
        logic [63:0]  y;
        logic [127:0] q;
        x = abs_q(a);
        y = abs_q(b);
        if ((x >> 32) >= y) begin
            fx_div = (a[63] != b[63]) ? chol_pkg::QMIN : chol_pkg::QMAX;
        end else begin
            q = ({64'd0, x} << 32) / {64'd0, y};
            fx_div = signed_sat(a[63] != b[63], q[63:0]);
        end
    endfunction

    function automatic chol_pkg::q_t fx_root(input logic [63:0] v);
        logic [127:0] x;
        logic [127:0] r;
        logic [127:0] t;
        x = {64'd0, v} << 32;
        r = 0;
        for (int b = 47; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= x) r = t;
        end
        fx_root = chol_pkg::q_t'(r[63:0]);
    endfunction

    function automatic int unknowns(input logic [4:0] o);
        unknowns = (o == 0) ? 1 : ((o > 16) ? 16 : int'(o));
    endfunction

    task automatic predict_solution();
        int           n;
        chol_pkg::q_t acc;
        chol_pkg::q_t piv;
        chol_pkg::q_t d;
        logic         err;
        solution_t    e;
        n = unknowns(order_model);
        err = 1'b0;
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int k = 0; k < i; k++)
                acc = sat_sum(acc, fx_mul(coef_model[i*16+k], coef_model[i*16+k]), 1'b0);
            piv = fx_root(abs_q(sat_sum(coef_model[i*16+i], acc, 1'b1)));
            coef_model[i*16+i] = piv;
            if (piv == 0) err = 1'b1;
            for (int j = i + 1; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < i; k++)
                    acc = sat_sum(acc, fx_mul(coef_model[j*16+k], coef_model[i*16+k]), 1'b0);
                coef_model[j*16+i] = (piv != 0) ?
                    fx_div(sat_sum(coef_model[j*16+i], acc, 1'b1), piv) : chol_pkg::q_t'(0);
            end
        end
        for (int i = 0; i < n; i++) begin
            d = coef_model[i*16+i];
            acc = 0;
            for (int j = 0; j < i; j++)
                acc = sat_sum(acc, fx_mul(coef_model[i*16+j], rhs_model[j]), 1'b0);
            rhs_model[i] = (d != 0) ?
                fx_div(sat_sum(rhs_model[i], acc, 1'b1), d) : chol_pkg::q_t'(0);
        end
        for (int i = n - 1; i >= 0; i--) begin
            d = coef_model[i*16+i];
            acc = 0;
            for (int j = i + 1; j < n; j++)
                acc = sat_sum(acc, fx_mul(coef_model[j*16+i], rhs_model[j]), 1'b0);
            rhs_model[i] = (d != 0) ?
                fx_div(sat_sum(rhs_model[i], acc, 1'b1), d) : chol_pkg::q_t'(0);
        end
        for (int k = 0; k < n; k++) begin
            e.index = 4'(k);
            e.solution = rhs_model[k];
            e.last = (k == n - 1);
            e.pivot_error = err;
            solution_q.push_back(e);
        end
        solves++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) pick_gap = 0;
        else if (r < 92) pick_gap = $urandom_range(1, 3);
        else pick_gap = $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic [1:0] f, input logic [3:0] r,
                                input logic [3:0] c, input chol_pkg::q_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_row   <= r;
        s_col   <= c;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        case (f)
            chol_pkg::FUNC_MAT:   coef_model[{r, c}] = v;
            chol_pkg::FUNC_RHS:   rhs_model[r] = v;
            chol_pkg::FUNC_SOLVE: predict_solution();
            default: ;
        endcase
        if (f != FUNC_NONE) requests++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (solution_q.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_order(input logic [4:0] o);
        s_valid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= o;
        do @(posedge aclk); while (!cfg_ready);
        order_model = o;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic chol_pkg::q_t rand_full();
        rand_full = chol_pkg::q_t'({$urandom(), $urandom()});
    endfunction

    function automatic chol_pkg::q_t rand_fraction();
        logic b;
        b = $urandom_range(0, 1);
        rand_fraction = chol_pkg::q_t'({{32{b}}, 32'($urandom())});
    endfunction

    // diagonally dominant system with random content, some noise mixed in
    task automatic load_system(input int n, input int noise_pct);
        chol_pkg::q_t v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if ($urandom_range(0, 99) < noise_pct) v = rand_full();
                else if (r == c)
                    v = chol_pkg::q_t'({32'(n + $urandom_range(1, 8)), 32'($urandom())});
                else v = rand_fraction();
                send_request(chol_pkg::FUNC_MAT, 4'(r), 4'(c), v);
            end
            if ($urandom_range(0, 9) == 0 && r < 15)
                send_request(chol_pkg::FUNC_MAT, 4'(r), 4'($urandom_range(r + 1, 15)),
                             rand_full());
            if ($urandom_range(0, 9) == 0)
                send_request(FUNC_NONE, 4'($urandom()), 4'($urandom()), rand_full());
        end
        for (int r = 0; r < n; r++) begin
            if ($urandom_range(0, 99) < noise_pct) v = rand_full();
            else v = chol_pkg::q_t'({{24{v[0]}}, 40'({$urandom(), $urandom()})});
            send_request(chol_pkg::FUNC_RHS, 4'(r), 4'($urandom()), v);
        end
    endtask

    task automatic test_single_unknown();
        write_order(5'd0);
        send_request(chol_pkg::FUNC_MAT, 4'd0, 4'd0, chol_pkg::QMAX);
        send_request(chol_pkg::FUNC_RHS, 4'd0, 4'hF, chol_pkg::QMIN);
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
        send_request(chol_pkg::FUNC_MAT, 4'd0, 4'd0, chol_pkg::QMIN);
        send_request(chol_pkg::FUNC_RHS, 4'd0, 4'd0, chol_pkg::QMAX);
        send_request(chol_pkg::FUNC_SOLVE, 4'hF, 4'hF, chol_pkg::QMIN);
        write_order(5'd1);
        send_request(chol_pkg::FUNC_MAT, 4'd0, 4'd0, chol_pkg::q_t'(64'h0000_0004_0000_0000));
        send_request(chol_pkg::FUNC_RHS, 4'd0, 4'd0, chol_pkg::q_t'(64'hFFFF_FFFA_0000_0000));
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
    endtask

    task automatic test_zero_pivot();
        write_order(5'd2);
        send_request(chol_pkg::FUNC_MAT, 4'd0, 4'd0, 0);
        send_request(chol_pkg::FUNC_MAT, 4'd1, 4'd0, chol_pkg::q_t'(64'h1_0000_0000));
        send_request(chol_pkg::FUNC_MAT, 4'd1, 4'd1, chol_pkg::q_t'(64'h4_0000_0000));
        send_request(chol_pkg::FUNC_RHS, 4'd0, 4'd0, chol_pkg::q_t'(64'h1_0000_0000));
        send_request(chol_pkg::FUNC_RHS, 4'd1, 4'd0, chol_pkg::q_t'(64'h2_0000_0000));
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
        send_request(chol_pkg::FUNC_MAT, 4'd0, 4'd0, chol_pkg::q_t'(64'h1_0000_0000));
        send_request(chol_pkg::FUNC_MAT, 4'd1, 4'd0, chol_pkg::q_t'(64'h1_0000_0000));
        send_request(chol_pkg::FUNC_MAT, 4'd1, 4'd1, chol_pkg::q_t'(64'h1_0000_0000));
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
    endtask

    task automatic test_ignored_and_repeat();
        send_request(FUNC_NONE, 4'hF, 4'hF, chol_pkg::QMAX);
        send_request(FUNC_NONE, 4'd0, 4'd0, 0);
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
    endtask

    task automatic test_largest_order();
        write_order(5'd31);
        load_system(16, 3);
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
        write_order(5'd16);
        send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
    endtask

    task automatic test_random_systems();
        int n;
        int round;
        logic [4:0] o;
        round = 0;
        while (requests < 310) begin
            o = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 6));
            write_order(o);
            n = unknowns(o);
            load_system(n, ($urandom_range(0, 3) == 0) ? 30 : 0);
            send_request(chol_pkg::FUNC_SOLVE, 4'($urandom()), 4'($urandom()), rand_full());
            // in round 3, hold off until the block has fully drained
            if (round == 3) begin
                s_valid <= 1'b0;
                while (solution_q.size() != 0) @(negedge aclk);
            end
            if ($urandom_range(0, 3) == 0) begin
                for (int r = 0; r < n; r++)
                    send_request(chol_pkg::FUNC_RHS, 4'(r), 4'd0, rand_fraction());
                send_request(chol_pkg::FUNC_SOLVE, 4'd0, 4'd0, 0);
            end
            round++;
        end
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        solution_t e;
        if (aresetn && m_valid && m_ready) begin
            results++;
            if (solution_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: index %0d solution %h",
                         $time, m_index, m_solution);
            end else begin
                e = solution_q.pop_front();
                if (m_index !== e.index) begin
                    errors++;
                    $display("%0t: index expected %0d actual %0d", $time, e.index, m_index);
                end
                if (m_solution !== e.solution) begin
                    errors++;
                    $display("%0t: solution[%0d] expected %h actual %h",
                             $time, e.index, e.solution, m_solution);
                end
                if (m_last !== e.last) begin
                    errors++;
                    $display("%0t: last[%0d] expected %b actual %b",
                             $time, e.index, e.last, m_last);
                end
                if (m_pivot_error !== e.pivot_error) begin
                    errors++;
                    $display("%0t: pivot_error[%0d] expected %b actual %b",
                             $time, e.index, e.pivot_error, m_pivot_error);
                end
            end
        end
    end

    initial begin
        errors = 0;
        requests = 0;
        solves = 0;
        results = 0;
        order_model = 5'd16;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = chol_pkg::FUNC_MAT;
        s_row = 4'd0;
        s_col = 4'd0;
        s_value = 0;
        cfg_valid = 1'b0;
        cfg_data = 5'd0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_single_unknown();
        test_zero_pivot();
        test_ignored_and_repeat();
        test_largest_order();
        test_random_systems();

        s_valid <= 1'b0;
        while (solution_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Ran %0d requests and %0d solves, checked %0d solution elements,",
                 requests, solves, results);
        $display("orders 0 to 31, zero pivots, saturation and repeated solves included.");
        if (errors == 0) begin
            $display("cholesky_linear_solver: match");
        end else begin
            $display("cholesky_linear_solver: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
